### rtl/aes_pkg.sv
package aes_pkg;

  localparam int TIME_BITS  = 24;
  localparam int PIX_BITS   = 16;
  localparam int TRY_BITS   = 5;
  localparam int MAX_TRIES  = 16;
  localparam int CFG_BITS   = 2;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [TIME_BITS-1:0] TIME_LO_RST = TIME_BITS'(54000);
  localparam logic [TIME_BITS-1:0] TIME_HI_RST = TIME_BITS'(1000000);
  localparam logic [PIX_BITS-1:0]  LOWER_RST   = PIX_BITS'(33000);
  localparam logic [PIX_BITS-1:0]  UPPER_RST   = PIX_BITS'(54000);

  typedef enum logic [CFG_BITS-1:0] {
    REG_TIME_LO = 2'd0,
    REG_TIME_HI = 2'd1,
    REG_LOWER   = 2'd2,
    REG_UPPER   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef enum logic {
    JOB_START = 1'b0,
    JOB_FRAME = 1'b1
  } job_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_MID    = 3'd1,
    PH_AT_MAX = 3'd2,
    PH_AT_MIN = 3'd3,
    PH_SEARCH = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef struct packed {
    job_kind_t           kind;
    logic [PIX_BITS-1:0] frame_max;
  } job_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_lo;
    logic [TIME_BITS-1:0] time_hi;
    logic [PIX_BITS-1:0]  lower_bound;
    logic [PIX_BITS-1:0]  upper_bound;
  } cfg_t;

  // half the span from lo to hi, zero when the span is empty
  function automatic logic [TIME_BITS-1:0] half_span(input logic [TIME_BITS-1:0] lo,
                                                     input logic [TIME_BITS-1:0] hi);
    logic [TIME_BITS-1:0] diff;
    diff = hi - lo;
    return (hi > lo) ? (diff >> 1) : '0;
  endfunction

endpackage

### rtl/aes_front.sv
module aes_front import aes_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  opcode_t             opcode,
  input  logic [PIX_BITS-1:0] pixel_value,
  input  logic                last_pixel,
  output logic                push,
  output job_t                push_job
);

  logic [PIX_BITS-1:0] run_max_r, run_max_nxt;
  logic [PIX_BITS-1:0] new_max;

  assign new_max = (pixel_value > run_max_r) ? pixel_value : run_max_r;

  always_comb begin
    run_max_nxt        = run_max_r;
    push               = 1'b0;
    push_job.kind      = JOB_START;
    push_job.frame_max = '0;
    if (acc) begin
      if (opcode == OP_START) begin
        run_max_nxt = '0;
        push        = 1'b1;
      end else if (last_pixel) begin
        // frame end: hand the finished maximum to the back end
        run_max_nxt        = '0;
        push               = 1'b1;
        push_job.kind      = JOB_FRAME;
        push_job.frame_max = new_max;
      end else begin
        run_max_nxt = new_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_max_r <= '0;
    end else begin
      run_max_r <= run_max_nxt;
    end
  end

endmodule

### rtl/aes_queue.sv
module aes_queue import aes_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t                  mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_BITS-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == Q_CNT_BITS'(Q_DEPTH));
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_BITS'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

### rtl/aes_back.sv
module aes_back import aes_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  job_t                 head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TIME_BITS-1:0] out_itime,
  output logic                 out_final,
  output logic [PIX_BITS-1:0]  out_fmax
);

  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] trial_r, trial_nxt;
  logic [TIME_BITS-1:0] step_r, step_nxt;
  logic [TRY_BITS-1:0]  try_r, try_nxt;

  logic                 out_valid_r;
  logic [TIME_BITS-1:0] out_itime_r;
  logic                 out_final_r;
  logic [PIX_BITS-1:0]  out_fmax_r;

  logic                 emit, fin;
  logic [TIME_BITS-1:0] res_time;

  logic                 too_bright, too_dark;
  logic [TIME_BITS-1:0] span_mid, half_max, span_up, span_dn;
  logic [TIME_BITS-1:0] step_h, t_up, t_dn, t_adj;
  logic [TIME_BITS:0]   sum_up;
  logic [TRY_BITS-1:0]  try_inc;
  logic                 hit_max, hit_min, tries_out;

  assign pop = !empty && (!out_valid_r || out_ready);

  // frame classification; too bright wins when bounds cross
  assign too_bright = head.frame_max > cfg.upper_bound;
  assign too_dark   = !too_bright && (head.frame_max < cfg.lower_bound);

  assign span_mid = half_span(cfg.time_lo, cfg.time_hi);
  assign half_max = cfg.time_hi >> 1;
  assign span_up  = half_span(half_max, cfg.time_hi);
  assign span_dn  = half_span(cfg.time_lo, half_max);

  // one halving step, saturating both ways
  assign step_h    = step_r >> 1;
  assign sum_up    = {1'b0, trial_r} + {1'b0, step_h};
  assign t_up      = sum_up[TIME_BITS] ? '1 : sum_up[TIME_BITS-1:0];
  assign t_dn      = (step_h > trial_r) ? '0 : trial_r - step_h;
  assign t_adj     = too_dark ? t_up : t_dn;
  assign hit_max   = t_adj >= cfg.time_hi;
  assign hit_min   = t_adj <= cfg.time_lo;
  assign try_inc   = try_r + 1'b1;
  assign tries_out = try_inc >= TRY_BITS'(MAX_TRIES);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (pop) begin
      if (head.kind == JOB_START) begin
        phase_nxt = PH_MID;
      end else begin
        unique case (phase_r)
          PH_MID: begin
            if (too_dark)        phase_nxt = PH_AT_MAX;
            else if (too_bright) phase_nxt = PH_AT_MIN;
            else                 phase_nxt = PH_DONE;
          end
          PH_AT_MAX: phase_nxt = too_bright ? PH_SEARCH : PH_DONE;
          PH_AT_MIN: phase_nxt = too_dark ? PH_SEARCH : PH_DONE;
          PH_SEARCH: begin
            if (!too_dark && !too_bright)          phase_nxt = PH_DONE;
            else if (hit_max || hit_min || tries_out) phase_nxt = PH_DONE;
            else                                   phase_nxt = PH_SEARCH;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    trial_nxt = trial_r;
    step_nxt  = step_r;
    try_nxt   = try_r;
    emit      = 1'b0;
    fin       = 1'b0;
    res_time  = trial_r;
    if (pop) begin
      if (head.kind == JOB_START) begin
        trial_nxt = span_mid;
        step_nxt  = '0;
        try_nxt   = '0;
        emit      = 1'b1;
        res_time  = span_mid;
      end else begin
        unique case (phase_r)
          PH_MID: begin
            emit = 1'b1;
            if (too_dark) begin
              trial_nxt = cfg.time_hi;
            end else if (too_bright) begin
              trial_nxt = cfg.time_lo;
            end else begin
              fin = 1'b1;
            end
            res_time = trial_nxt;
          end
          PH_AT_MAX: begin
            emit = 1'b1;
            if (too_bright) begin
              step_nxt  = span_up;
              trial_nxt = half_max + span_up;
              try_nxt   = '0;
            end else begin
              fin = 1'b1;
            end
            res_time = trial_nxt;
          end
          PH_AT_MIN: begin
            emit = 1'b1;
            if (too_dark) begin
              step_nxt  = span_dn;
              trial_nxt = cfg.time_lo + span_dn;
              try_nxt   = '0;
            end else begin
              fin = 1'b1;
            end
            res_time = trial_nxt;
          end
          PH_SEARCH: begin
            emit     = 1'b1;
            step_nxt = step_h;
            if (!too_dark && !too_bright) begin
              fin = 1'b1;
            end else if (hit_max) begin
              trial_nxt = cfg.time_hi;
              fin       = 1'b1;
            end else if (hit_min) begin
              trial_nxt = cfg.time_lo;
              fin       = 1'b1;
            end else begin
              trial_nxt = t_adj;
              try_nxt   = try_inc;
              fin       = tries_out;
            end
            res_time = trial_nxt;
          end
          default: emit = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      trial_r     <= '0;
      step_r      <= '0;
      try_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      trial_r <= trial_nxt;
      step_r  <= step_nxt;
      try_r   <= try_nxt;
      if (pop && emit)    out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_itime_r <= res_time;
      out_final_r <= fin;
      out_fmax_r  <= (head.kind == JOB_START) ? '0 : head.frame_max;
    end
  end

  assign out_valid = out_valid_r;
  assign out_itime = out_itime_r;
  assign out_final = out_final_r;
  assign out_fmax  = out_fmax_r;

  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && emit && fin) |=> phase_r == PH_DONE)
    else $error("final result without done phase");

  a_try_limit: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SEARCH |-> try_r < TRY_BITS'(MAX_TRIES))
    else $error("search past try limit");

  a_start_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == JOB_START) |=> (phase_r == PH_MID && out_valid && !out_final))
    else $error("start did not issue a midpoint request");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == JOB_FRAME && (phase_r == PH_IDLE || phase_r == PH_DONE))
      |-> !emit)
    else $error("result from an idle search");

endmodule

### rtl/auto_exposure_search.sv
// Channel   Direction  Handshake            Payload
// in_       slave      in_tvalid/in_tready  tdata: pixel_value; tuser: opcode; tlast: last_pixel
// out_      master     out_tvalid/out_tready tdata: itime, frame_max; tuser: is_final
// cfg_      write      cfg_we               cfg_addr: register index; cfg_wdata: value
//
// One input transaction per clock while the job queue is not full; one result per clock out while out_tready is high.
// Front end tracks the frame maximum; a 4-entry job queue feeds the back end,
// which applies one search step per job and registers the result into the output register.
// A start or last pixel passes through the job queue and then the output register before its result appears.
// rst_n is synchronous, active low; configuration registers return to their reset defaults.
// in_tready drops only when the job queue is full (output stalled long enough).
module auto_exposure_search import aes_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_BITS-1:0]    in_tdata,   // [15:0] pixel_value
  input  logic                   in_tuser,   // [0] opcode
  input  logic                   in_tlast,   // last_pixel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TIME_BITS+PIX_BITS-1:0] out_tdata, // [23:0] itime, [39:24] frame_max
  output logic                   out_tuser,  // [0] is_final
  input  logic                   cfg_we,
  input  logic [CFG_BITS-1:0]    cfg_addr,
  input  logic [TIME_BITS-1:0]   cfg_wdata
);

  cfg_t cfg_r;
  logic in_acc;
  logic push, pop, q_empty, q_full;
  job_t push_job, head;
  logic [TIME_BITS-1:0] res_itime;
  logic [PIX_BITS-1:0]  res_fmax;

  // configuration registers; software must write them only while the search is quiet (not enforced by the block)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_lo     <= TIME_LO_RST;
      cfg_r.time_hi     <= TIME_HI_RST;
      cfg_r.lower_bound <= LOWER_RST;
      cfg_r.upper_bound <= UPPER_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_TIME_LO: cfg_r.time_lo     <= cfg_wdata;
        REG_TIME_HI: cfg_r.time_hi     <= cfg_wdata;
        REG_LOWER:   cfg_r.lower_bound <= cfg_wdata[PIX_BITS-1:0];
        REG_UPPER:   cfg_r.upper_bound <= cfg_wdata[PIX_BITS-1:0];
        default:     cfg_r             <= cfg_r;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  aes_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .opcode      (opcode_t'(in_tuser)),
    .pixel_value (in_tdata),
    .last_pixel  (in_tlast),
    .push        (push),
    .push_job    (push_job)
  );

  aes_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  aes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_itime (res_itime),
    .out_final (out_tuser),
    .out_fmax  (res_fmax)
  );

  assign out_tdata = {res_fmax, res_itime};

endmodule
